FILE: rtl/core/imb_pkg.sv
package imb_pkg;

   localparam int IntWidth  = 64;
   localparam int WidthBits = 7;
   localparam int CsrIdxBits = 2;

   localparam logic [CsrIdxBits-1:0] CSR_EXP_WIDTH  = 2'd0;
   localparam logic [CsrIdxBits-1:0] CSR_FRAC_WIDTH = 2'd1;

   localparam logic [WidthBits-1:0] EXP_WIDTH_RESET  = 7'd4;
   localparam logic [WidthBits-1:0] FRAC_WIDTH_RESET = 7'd4;

   // Request as captured at the input.
   typedef struct packed {
      logic                 valid;
      logic [IntWidth-1:0]  value;
      logic [WidthBits-1:0] exp_width;
      logic [WidthBits-1:0] frac_width;
      logic                 width_error;
   } cap_type;

   // After the bit length is known.
   typedef struct packed {
      logic                 valid;
      logic [IntWidth-1:0]  value;
      logic [WidthBits-1:0] exp_width;
      logic [WidthBits-1:0] frac_width;
      logic                 width_error;
      logic [WidthBits-1:0] bit_len;
   } len_type;

   // After exponent, saturation and significand extraction.
   typedef struct packed {
      logic                 valid;
      logic [IntWidth-1:0]  value;
      logic [WidthBits-1:0] exp_width;
      logic [WidthBits-1:0] frac_width;
      logic                 width_error;
      logic                 pass;
      logic                 sat;
      logic [WidthBits-1:0] expo;
      logic [IntWidth-1:0]  frac;
   } norm_type;

   // All ones in the low n bits; n of IntWidth or more gives all ones.
   function automatic logic [IntWidth-1:0] ones_below(input logic [WidthBits-1:0] n);
      logic [IntWidth-1:0] r;
      if (n >= WidthBits'(IntWidth)) begin
         r = '1;
      end else begin
         r = (IntWidth'(1) << n) - IntWidth'(1);
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/imb_len_stage.sv
module imb_len_stage
   import imb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cap_type cap,
   output len_type len
);

   localparam int Groups = IntWidth / 8;

   len_type        len_ff, len_in;
   logic [3:0]     grp_len [Groups];
   logic [WidthBits-1:0] total;

   // Bit length in two levels: within each byte, then the highest nonzero byte.
   always_comb begin
      for (int g = 0; g < Groups; g++) begin
         grp_len[g] = 4'd0;
         for (int b = 0; b < 8; b++) begin
            if (cap.value[g*8+b]) begin
               grp_len[g] = 4'(b + 1);
            end
         end
      end
      total = '0;
      for (int g = 0; g < Groups; g++) begin
         if (grp_len[g] != 4'd0) begin
            total = WidthBits'(g * 8) + WidthBits'(grp_len[g]);
         end
      end
   end

   always_comb begin
      len_in.valid       = cap.valid;
      len_in.value       = cap.value;
      len_in.exp_width   = cap.exp_width;
      len_in.frac_width  = cap.frac_width;
      len_in.width_error = cap.width_error;
      len_in.bit_len     = total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff.valid <= 1'b0;
      end else begin
         len_ff <= len_in;
      end
   end

   assign len = len_ff;

endmodule

FILE: rtl/core/imb_norm_stage.sv
module imb_norm_stage
   import imb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  len_type  len,
   output norm_type norm
);

   norm_type             norm_ff, norm_in;
   logic [WidthBits-1:0] expo;
   logic [5:0]           shift;
   logic [WidthBits-1:0] expo_hi;

   always_comb begin
      expo  = len.bit_len - len.frac_width;
      shift = 6'(expo - WidthBits'(1));
      expo_hi = expo >> len.exp_width[2:0];

      norm_in.valid       = len.valid;
      norm_in.value       = len.value;
      norm_in.exp_width   = len.exp_width;
      norm_in.frac_width  = len.frac_width;
      norm_in.width_error = len.width_error;
      norm_in.pass        = (len.bit_len <= len.frac_width);
      norm_in.expo        = expo;
      // An exponent field of seven or more bits holds any exponent.
      norm_in.sat         = (len.exp_width < WidthBits'(WidthBits)) && (expo_hi != '0);
      norm_in.frac        = (len.value >> shift) & ones_below(len.frac_width);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff.valid <= 1'b0;
      end else begin
         norm_ff <= norm_in;
      end
   end

   assign norm = norm_ff;

endmodule

FILE: rtl/core/imb_pack_stage.sv
module imb_pack_stage
   import imb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  norm_type            norm,
   output logic                valid,
   output logic [IntWidth-1:0] code,
   output logic                width_error
);

   logic                valid_ff, valid_in;
   logic [IntWidth-1:0] code_ff, code_in;
   logic                err_ff, err_in;

   always_comb begin
      valid_in = norm.valid;
      err_in   = norm.width_error;
      if (norm.width_error) begin
         code_in = '0;
      end else if (norm.pass) begin
         code_in = norm.value;
      end else if (norm.sat) begin
         code_in = ones_below(norm.exp_width + norm.frac_width);
      end else begin
         code_in = (IntWidth'(norm.expo) << norm.frac_width) | norm.frac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
      err_ff  <= err_in;
   end

   assign valid       = valid_ff;
   assign code        = code_ff;
   assign width_error = err_ff;

endmodule

FILE: rtl/core/integer_to_minifloat_bucket_unit.sv
// Encodes a 64-bit unsigned request into a minifloat code with configurable exponent and
// significand widths. A new request is taken in every cycle that busy is low (busy is high
// only during reset and in the cycle after it); each result appears for one cycle, marked
// by rsp_valid, through a four-stage pipeline (capture, bit length, exponent and
// significand, packing). The receiver cannot stall, so results are never held.
// Write exp_width and frac_width only while no request is in flight.
module integer_to_minifloat_bucket_unit
   import imb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [IntWidth-1:0]   req_sample_value,
   output logic                  rsp_valid,
   output logic [IntWidth-1:0]   rsp_code,
   output logic                  rsp_width_error,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CsrIdxBits-1:0] csr_index,
   input  logic [WidthBits-1:0]  csr_wdata
);

   logic                 busy_ff;
   logic [WidthBits-1:0] exp_width_ff, exp_width_in;
   logic [WidthBits-1:0] frac_width_ff, frac_width_in;
   cap_type              cap_ff, cap_in;
   len_type              len;
   norm_type             norm;
   logic [WidthBits:0]   width_sum;

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   always_comb begin
      exp_width_in  = exp_width_ff;
      frac_width_in = frac_width_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXP_WIDTH:  exp_width_in  = csr_wdata;
            CSR_FRAC_WIDTH: frac_width_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      width_sum          = {1'b0, exp_width_ff} + {1'b0, frac_width_ff};
      cap_in.valid       = start && !busy_ff;
      cap_in.value       = req_sample_value;
      cap_in.exp_width   = exp_width_ff;
      cap_in.frac_width  = frac_width_ff;
      cap_in.width_error = (width_sum > (WidthBits + 1)'(IntWidth));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         exp_width_ff  <= EXP_WIDTH_RESET;
         frac_width_ff <= FRAC_WIDTH_RESET;
         cap_ff.valid  <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         exp_width_ff  <= exp_width_in;
         frac_width_ff <= frac_width_in;
         cap_ff        <= cap_in;
      end
   end

   imb_len_stage u_len (
      .clock (clock),
      .reset (reset),
      .cap   (cap_ff),
      .len   (len)
   );

   imb_norm_stage u_norm (
      .clock (clock),
      .reset (reset),
      .len   (len),
      .norm  (norm)
   );

   imb_pack_stage u_pack (
      .clock       (clock),
      .reset       (reset),
      .norm        (norm),
      .valid       (rsp_valid),
      .code        (rsp_code),
      .width_error (rsp_width_error)
   );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench
   import imb_pkg::*;
;

   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 8;

   typedef struct packed {
      logic [IntWidth-1:0] code;
      logic                width_error;
   } bucket_code_type;

   class bucket_scoreboard;
      logic [WidthBits-1:0] exp_width;
      logic [WidthBits-1:0] frac_width;
      bucket_code_type      expected_codes[$];
      int                   errors;

      function new();
         exp_width  = EXP_WIDTH_RESET;
         frac_width = FRAC_WIDTH_RESET;
         errors     = 0;
      endfunction

      function void set_register(logic [CsrIdxBits-1:0] idx, logic [WidthBits-1:0] data);
         case (idx)
            CSR_EXP_WIDTH:  exp_width = data;
            CSR_FRAC_WIDTH: frac_width = data;
            default: ;
         endcase
      endfunction

      function logic [IntWidth-1:0] low_ones(int n);
         if (n >= IntWidth) begin
            return '1;
         end
         return (IntWidth'(1) << n) - IntWidth'(1);
      endfunction

      function bucket_code_type encode_sample(logic [IntWidth-1:0] v);
         bucket_code_type r;
         int e;
         int f;
         int w;
         int expo;
         int i;
         e = exp_width;
         f = frac_width;
         r.code = '0;
         r.width_error = 1'b0;
         if (e + f > IntWidth) begin
            r.width_error = 1'b1;
            return r;
         end
         w = 0;
         for (i = 0; i < IntWidth; i++) begin
            if (v[i]) begin
               w = i + 1;
            end
         end
         if (w <= f) begin
            r.code = v;
         end else begin
            // The exponent counts bits above the significand; the leading one is implied.
            expo = w - f;
            if (IntWidth'(expo) > low_ones(e)) begin
               r.code = low_ones(e + f);
            end else begin
               r.code = (IntWidth'(expo) << f) | ((v >> (expo - 1)) & low_ones(f));
            end
         end
         return r;
      endfunction

      function void note_request(logic [IntWidth-1:0] v);
         expected_codes.push_back(encode_sample(v));
      endfunction

      function void check_result(logic [IntWidth-1:0] code, logic width_error);
         bucket_code_type want;
         if (expected_codes.size() == 0) begin
            $display("%0t: unexpected result, expected none, got code %h width_error %b",
                     $time, code, width_error);
            errors++;
            return;
         end
         want = expected_codes.pop_front();
         if (code !== want.code) begin
            $display("%0t: code mismatch, expected %h, got %h", $time, want.code, code);
            errors++;
         end
         if (width_error !== want.width_error) begin
            $display("%0t: width_error mismatch, expected %b, got %b",
                     $time, want.width_error, width_error);
            errors++;
         end
      endfunction

      function int pending();
         return expected_codes.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [IntWidth-1:0]   req_sample_value = '0;
   logic                  rsp_valid;
   logic [IntWidth-1:0]   rsp_code;
   logic                  rsp_width_error;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CsrIdxBits-1:0] csr_index = CSR_EXP_WIDTH;
   logic [WidthBits-1:0]  csr_wdata = '0;

   bucket_scoreboard sb = new();
   int unsigned cycle_count = 0;
   int sender_idle_pct = 0;

   integer_to_minifloat_bucket_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_code         (rsp_code),
      .rsp_width_error  (rsp_width_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Inputs only change at the falling edge, so everything seen here is stable.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.set_register(csr_index, csr_wdata);
         end
         if (start && !busy) begin
            sb.note_request(req_sample_value);
         end
         if (rsp_valid) begin
            sb.check_result(rsp_code, rsp_width_error);
         end
      end
   end

   task automatic send_sample(input logic [IntWidth-1:0] v);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_sample_value <= v;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic drain_requests();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() > 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [CsrIdxBits-1:0] idx, input int data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[WidthBits-1:0];
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_widths(input int e, input int f);
      drain_requests();
      write_register(CSR_EXP_WIDTH, e);
      write_register(CSR_FRAC_WIDTH, f);
   endtask

   function automatic logic [IntWidth-1:0] sample_of_length(int len);
      logic [IntWidth-1:0] v;
      if (len <= 0) begin
         return '0;
      end
      v = {$urandom, $urandom} >> (IntWidth - len);
      v[len-1] = 1'b1;
      return v;
   endfunction

   // Mostly values with a chosen bit length, so every exponent gets hit, with some
   // lengths aimed at the point where the exponent saturates.
   function automatic logic [IntWidth-1:0] random_sample();
      int e;
      int f;
      int len;
      e = sb.exp_width;
      f = sb.frac_width;
      case ($urandom_range(9))
         0, 1: return {$urandom, $urandom};
         2, 3, 4, 5: return sample_of_length($urandom_range(IntWidth));
         6, 7: begin
            if (e >= 7) begin
               len = IntWidth;
            end else begin
               len = (1 << e) - 1 + f + $urandom_range(2) - 1;
            end
            if (len > IntWidth) begin
               len = IntWidth;
            end
            return sample_of_length(len);
         end
         8: return IntWidth'($urandom_range(300));
         default: begin
            len = $urandom_range(IntWidth - 1);
            return (IntWidth'(1) << len) - IntWidth'($urandom_range(1));
         end
      endcase
   endfunction

   int cfg_exp[10]  = '{4, 0, 64, 0, 1, 63, 3, 11, 2, 0};
   int cfg_frac[10] = '{4, 0, 0, 64, 63, 1, 5, 52, 1, 0};
   int idle_pcts[3] = '{0, 74, 33};

   initial begin
      int phase;
      int n;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Reset widths: four exponent bits, four significand bits.
      send_sample(64'd0);
      send_sample(64'd1);
      send_sample(64'd15);
      send_sample(64'd16);
      send_sample(64'd31);
      send_sample(64'd32);
      send_sample(64'h4_0000);
      send_sample(64'h7_FFFF);
      send_sample(64'h8_0000);
      send_sample(64'h8000_0000_0000_0000);
      send_sample('1);
      send_sample(64'h5555_5555_5555_5555);
      send_sample(64'hAAAA_AAAA_AAAA_AAAA);

      // Without exponent bits every normal value saturates.
      set_widths(0, 4);
      send_sample(64'd15);
      send_sample(64'd16);
      set_widths(0, 0);
      send_sample(64'd0);
      send_sample(64'd1);
      set_widths(64, 0);
      send_sample(64'd1);
      send_sample(64'h8000_0000_0000_0000);
      send_sample('1);
      set_widths(0, 64);
      send_sample('1);
      set_widths(32, 32);
      send_sample('1);
      send_sample(64'h0000_0001_0000_0000);
      // Combined widths beyond the integer width flag an error.
      set_widths(127, 127);
      send_sample(64'd5);
      set_widths(33, 32);
      send_sample('1);

      for (phase = 0; phase < 12; phase++) begin
         if (phase < 10) begin
            set_widths(cfg_exp[phase], cfg_frac[phase]);
         end else if (phase == 10) begin
            set_widths($urandom_range(12), $urandom_range(60));
         end else begin
            set_widths($urandom_range(127), $urandom_range(127));
         end
         sender_idle_pct = idle_pcts[phase % 3];
         for (n = 0; n < 55; n++) begin
            send_sample(random_sample());
         end
      end

      drain_requests();
      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/imb_pkg.sv
rtl/core/imb_len_stage.sv
rtl/core/imb_norm_stage.sv
rtl/core/imb_pack_stage.sv
rtl/core/integer_to_minifloat_bucket_unit.sv
tb/testbench.sv
